// File: hdl/assert_macros.svh
// Assertion helpers shared by the block's modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies another at the next edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
// Check that a condition always holds
`define ASSERT_ALWAYS(label, clk, rst, a) \
  label: assert property (@(posedge clk) disable iff (rst) (a)) \
    else $error("assertion failed");
`endif

// File: hdl/mvts_pkg.sv
`timescale 1ns / 1ps
package mvts_pkg;
  localparam int MaxTrips = 128;
  localparam int FillW = $clog2(MaxTrips + 1);
  localparam int AddrW = $clog2(MaxTrips);
  localparam int KeyW = 12;
  localparam logic [KeyW-1:0] KeySat = 12'd4094;
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  // Trip after classification: keys routed to stations
  typedef struct packed {
    logic [KeyW-1:0] key_a;
    logic [KeyW-1:0] key_b;
    logic            keep;
    logic            last;
  } trip_t;

  // Event count per station
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic       ovf;
  } result_t;
endpackage

// File: hdl/mvts_ram.sv
`timescale 1ns / 1ps
module mvts_ram #(
  parameter int Width = 12,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write one entry, read registered
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/mvts_front.sv
`timescale 1ns / 1ps
module mvts_front
  import mvts_pkg::*;
(
  input  logic        from_b,
  input  logic [10:0] depart_minute,
  input  logic [10:0] arrive_minute,
  input  logic        last_trip,
  input  logic [5:0]  turn,
  input  logic [FillW-1:0] held,
  output trip_t       trip
);
  logic [KeyW-1:0] dep_key;
  logic [12:0]     arr_sum;
  logic [KeyW-1:0] arr_key;

  // Build keys and decide whether the trip fits
  always_comb begin
    dep_key = {depart_minute, 1'b1};
    arr_sum = {1'b0, arrive_minute, 1'b0} + {6'd0, turn, 1'b0};
    arr_key = (arr_sum > {1'b0, KeySat}) ? KeySat : arr_sum[KeyW-1:0];
    trip.keep = (held < FillW'(MaxTrips));
    trip.last = last_trip;
    trip.key_a = from_b ? arr_key : dep_key;
    trip.key_b = from_b ? dep_key : arr_key;
  end
endmodule

// File: hdl/mvts_station.sv
`timescale 1ns / 1ps
module mvts_station
  import mvts_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            ins,
  input  logic [KeyW-1:0] key,
  input  logic            sweep,
  input  logic            clear,
  output logic            busy,
  output logic            done,
  output logic [7:0]      count
);
  `include "assert_macros.svh"
  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_CMP = 3'd2,
                         S_SW = 3'd3, S_SWD = 3'd4, S_DONE = 3'd5;
  logic [2:0] state;
  logic [FillW-1:0] fill, pos, idx;
  logic [KeyW-1:0] kin;
  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [KeyW-1:0] wdata, rdata;
  logic signed [FillW+1:0] level, deepest, level_dn;

  mvts_ram #(.Width(KeyW), .Depth(MaxTrips)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // Memory access: shift entries up during insertion
  always_comb begin
    we = 1'b0;
    waddr = pos[AddrW-1:0];
    wdata = kin;
    raddr = (state == S_SW || state == S_SWD) ? idx[AddrW-1:0]
                                              : pos[AddrW-1:0] - AddrW'(1);
    if (state == S_CMP) begin
      we = 1'b1;
      if (pos != '0 && rdata > kin) wdata = rdata;
    end
  end

  assign level_dn = level - (FillW+2)'(1);
  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign count = (deepest > 255) ? 8'd255 : deepest[7:0];

  // Insertion sort, then sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ins) begin
            kin <= key;
            pos <= fill;
            state <= (fill == '0) ? S_CMP : S_RD;
          end else if (sweep) begin
            idx <= '0;
            level <= '0;
            deepest <= '0;
            state <= (fill == '0) ? S_DONE : S_SW;
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (pos != '0 && rdata > kin) begin
            pos <= pos - 1'b1;
            state <= S_RD;
          end else begin
            fill <= fill + 1'b1;
            state <= S_IDLE;
          end
        end
        S_SW: begin
          idx <= idx + 1'b1;
          state <= S_SWD;
        end
        S_SWD: begin
          if (rdata[0]) begin
            level <= level_dn;
            if (-level_dn > deepest) deepest <= -level_dn;
          end else begin
            level <= level + 1'b1;
          end
          state <= (idx == fill) ? S_DONE : S_SW;
        end
        S_DONE: if (clear) begin
          fill <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_fill_cap, clk, rst, fill <= FillW'(MaxTrips))
  `ASSERT_NEXT(a_clear, clk, rst, state == S_DONE && clear, fill == '0)
endmodule

// File: hdl/mvts_back.sv
`timescale 1ns / 1ps
module mvts_back
  import mvts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  trip_t   q_trip,
  output logic    q_pop,
  output logic    res_valid,
  output result_t res,
  input  logic    res_take
);
  `include "assert_macros.svh"
  localparam logic [1:0] B_IDLE = 2'd0, B_INS = 2'd1, B_SW = 2'd2, B_OUT = 2'd3;
  logic [1:0] state;
  logic ins, sweep, clear, busy_a, busy_b, done_a, done_b, drop, last;
  logic [7:0] cnt_a, cnt_b;

  assign ins = (state == B_IDLE) && q_valid && q_trip.keep;
  assign q_pop = (state == B_IDLE) && q_valid;
  assign sweep = (state == B_SW) && !busy_a && !busy_b;
  assign clear = res_valid && res_take;

  mvts_station u_a (.clk, .rst, .ins, .key(q_trip.key_a), .sweep, .clear,
    .busy(busy_a), .done(done_a), .count(cnt_a));
  mvts_station u_b (.clk, .rst, .ins, .key(q_trip.key_b), .sweep, .clear,
    .busy(busy_b), .done(done_b), .count(cnt_b));

  assign res_valid = (state == B_OUT) && done_a && done_b;
  assign res = '{a: cnt_a, b: cnt_b, ovf: drop};

  // Sequence inserts, sweep and handoff
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      drop <= 1'b0;
      last <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: if (q_pop) begin
          if (!q_trip.keep) drop <= 1'b1;
          last <= q_trip.last;
          state <= q_trip.keep ? B_INS : (q_trip.last ? B_SW : B_IDLE);
        end
        B_INS: if (!busy_a && !busy_b) state <= last ? B_SW : B_IDLE;
        B_SW: if (sweep) state <= B_OUT;
        B_OUT: if (clear) begin
          drop <= 1'b0;
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst, res_valid && !res_take, res_valid)
  `ASSERT_ALWAYS(a_pop_idle, clk, rst, !q_pop || state == B_IDLE)
endmodule

// File: hdl/min_vehicles_two_station_sweep.sv
`timescale 1ns / 1ps
// Minimum vehicles for a two-station timetable. Trips are pushed one per cycle,
// while the queue is not full, into a 4-entry queue; the back end pops each
// trip and inserts its two keys into sorted per-station RAMs, reading and
// comparing each shifted entry in turn. The last trip triggers a sweep of the
// stored keys, after which one result waits until popped.
// Up to 128 trips are held per case; more are dropped and flagged.
module min_vehicles_two_station_sweep
  import mvts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        from_b,
  input  logic [10:0] depart_minute,
  input  logic [10:0] arrive_minute,
  input  logic        last_trip,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  start_at_a,
  output logic [7:0]  start_at_b,
  output logic        overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);
  `include "assert_macros.svh"
  logic [5:0] turn;
  logic [FillW-1:0] held;
  trip_t trip;
  trip_t q [QDepth];
  logic [QPtrW-1:0] wp, rp;
  logic [QPtrW:0] qcnt;
  logic acc, q_pop, res_valid;
  result_t res;

  assign cfg_ready = 1'b1;
  assign full = (qcnt == (QPtrW+1)'(QDepth));
  assign acc = push && !full;

  mvts_front u_front (.from_b, .depart_minute, .arrive_minute, .last_trip,
    .turn, .held, .trip);

  mvts_back u_back (.clk, .rst, .q_valid(qcnt != '0), .q_trip(q[rp]), .q_pop,
    .res_valid, .res, .res_take(pop));

  assign empty = !res_valid;
  assign start_at_a = res.a;
  assign start_at_b = res.b;
  assign overflow = res.ovf;

  // Hold config, queue and accepted-trip count for the case
  always_ff @(posedge clk) begin
    if (rst) begin
      turn <= '0;
      wp <= '0;
      rp <= '0;
      qcnt <= '0;
      held <= '0;
    end else begin
      if (cfg_valid) turn <= cfg_data;
      if (acc) begin
        wp <= wp + 1'b1;
        if (last_trip) held <= '0;
        else if (trip.keep) held <= held + 1'b1;
      end
      if (q_pop) rp <= rp + 1'b1;
      qcnt <= qcnt + (QPtrW+1)'(acc) - (QPtrW+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) q[wp] <= trip;
  end

  `ASSERT_ALWAYS(a_q_bound, clk, rst, qcnt <= (QPtrW+1)'(QDepth))
  `ASSERT_ALWAYS(a_no_under, clk, rst, !q_pop || qcnt != '0)
endmodule
